[hdl/ptcc_pkg.sv]
// Shared types, constants and fixed-point helpers for the pose transition clearance check.
`timescale 1ns / 1ps
package ptcc_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [33:0] qprod_t;
  typedef logic signed [65:0] acc_t;

  typedef word_t  mat_t [9];
  typedef qprod_t qp_t [10];

  typedef struct packed {
    logic  load;
    logic  last;
    logic  mob_first;
    logic  mob_second;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t quat_x;
    word_t quat_y;
    word_t quat_z;
    word_t quat_w;
  } req_t;

  localparam int DATA_W = 232;

  localparam word_t WS_PT [3] = '{32'sd655, 32'sd0, 32'sd6554};
  localparam word_t PALM [9] = '{32'sd655, 32'sd6554, 32'sd6554,
                                 32'sd655, 32'sd0, 32'sd0,
                                 32'sd655, -32'sd6554, 32'sd6554};

  function automatic word_t sat32(input acc_t v);
    if (v > 66'sh7FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sh80000000) begin
      return -32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Products are ordered xx, yy, zz, ww, xy, xz, yz, wx, wy, wz.
  function automatic mat_t quat_rot(input qp_t q);
    mat_t r;
    acc_t xx, yy, zz, ww, xy, xz, yz, wx, wy, wz, t;
    xx = 66'(q[0]);
    yy = 66'(q[1]);
    zz = 66'(q[2]);
    ww = 66'(q[3]);
    xy = 66'(q[4]);
    xz = 66'(q[5]);
    yz = 66'(q[6]);
    wx = 66'(q[7]);
    wy = 66'(q[8]);
    wz = 66'(q[9]);
    r[0] = sat32(ww + xx - yy - zz);
    t = xy - wz;
    r[1] = sat32(t + t);
    t = xz + wy;
    r[2] = sat32(t + t);
    t = xy + wz;
    r[3] = sat32(t + t);
    r[4] = sat32(ww - xx + yy - zz);
    t = yz - wx;
    r[5] = sat32(t + t);
    t = xz - wy;
    r[6] = sat32(t + t);
    t = yz + wx;
    r[7] = sat32(t + t);
    r[8] = sat32(ww - xx - yy + zz);
    return r;
  endfunction

endpackage

[hdl/ptcc_front.sv]
// Front end: accepts requests, decodes their kind and queues them for the back end.
`timescale 1ns / 1ps
module ptcc_front import ptcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic              s_tuser,
  input  logic              s_tlast,
  output logic              q_valid,
  input  logic              q_pop,
  output req_t              q_head
);

  localparam logic OP_LOAD = 1'b0;

  req_t       slots [2];
  req_t       incoming;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_head   = slots[rptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    incoming.load       = (s_tuser == OP_LOAD);
    incoming.last       = s_tlast;
    incoming.pos_x      = s_tdata[31:0];
    incoming.pos_y      = s_tdata[63:32];
    incoming.pos_z      = s_tdata[95:64];
    incoming.quat_x     = s_tdata[127:96];
    incoming.quat_y     = s_tdata[159:128];
    incoming.quat_z     = s_tdata[191:160];
    incoming.quat_w     = s_tdata[223:192];
    incoming.mob_first  = s_tdata[224];
    incoming.mob_second = s_tdata[225];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[hdl/ptcc_back.sv]
// Back end: sequences one shared multiplier through rotation, composition and the checks.
`timescale 1ns / 1ps
module ptcc_back import ptcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  req_t        q_head,
  input  logic [30:0] hand_radius,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_QUAT = 3'd1;
  localparam logic [2:0] PH_ROT  = 3'd2;
  localparam logic [2:0] PH_COMP = 3'd3;
  localparam logic [2:0] PH_CTR  = 3'd4;
  localparam logic [2:0] PH_SQ   = 3'd5;
  localparam logic [2:0] PH_ZCHK = 3'd6;
  localparam logic [2:0] PH_FIN  = 3'd7;

  localparam logic [2:0] WB_QP = 3'd0;
  localparam logic [2:0] WB_CR = 3'd1;
  localparam logic [2:0] WB_CT = 3'd2;
  localparam logic [2:0] WB_DD = 3'd3;
  localparam logic [2:0] WB_SQ = 3'd4;
  localparam logic [2:0] WB_HR = 3'd5;
  localparam logic [2:0] WB_ZM = 3'd6;
  localparam logic [2:0] WB_ZF = 3'd7;

  localparam logic [1:0] WHY_NONE  = 2'd0;
  localparam logic [1:0] WHY_CLOSE = 2'd1;
  localparam logic [1:0] WHY_BELOW = 2'd2;
  localparam logic [1:0] WHY_FIXED = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] idx;
    logic       first;
    logic       last;
  } tag_t;

  logic [2:0]         phase;
  logic [3:0]         g;
  logic [1:0]         k;
  req_t               cur;
  mat_t               rr;
  word_t              rt [3];
  logic               fm;
  logic               sm;
  mat_t               wr;
  mat_t               cr;
  word_t              ct [3];
  word_t              dd [3];
  qp_t                qp;
  acc_t               acc;
  logic signed [63:0] prod;
  logic               pv;
  tag_t               tag;
  logic [1:0]         why;
  logic               verdict;
  logic [1:0]         code;
  logic               ov;
  logic               out_ok;
  logic [1:0]         out_why;

  mat_t       rot_now;
  logic       issue;
  tag_t       itag;
  word_t      opa;
  word_t      opb;
  word_t      posk;
  logic [1:0] row;
  logic [1:0] col;
  logic [3:0] ai;
  logic [3:0] bi;
  logic [3:0] pi;
  acc_t       term;
  acc_t       init;
  acc_t       sum;
  logic       new_verdict;
  logic [1:0] new_code;
  logic       sweep_end;

  assign rot_now  = quat_rot(qp);
  assign q_pop    = (phase == PH_IDLE) && q_valid;
  assign m_tvalid = ov;
  assign m_tdata  = {5'd0, out_why, out_ok};

  always_comb begin
    if (g < 4'd3) begin
      row = 2'd0;
      col = g[1:0];
    end else if (g < 4'd6) begin
      row = 2'd1;
      col = 2'(g - 4'd3);
    end else if (g < 4'd9) begin
      row = 2'd2;
      col = 2'(g - 4'd6);
    end else begin
      row = 2'(g - 4'd9);
      col = 2'd0;
    end
    ai = 4'(row) * 4'd3 + 4'(k);
    bi = 4'(k) * 4'd3 + 4'(col);
    pi = 4'(g[1:0]) * 4'd3 + 4'(k);
    case (k)
      2'd0:    posk = cur.pos_x;
      2'd1:    posk = cur.pos_y;
      default: posk = cur.pos_z;
    endcase
  end

  always_comb begin
    issue = 1'b0;
    opa   = '0;
    opb   = '0;
    itag  = '0;
    unique case (phase)
      PH_QUAT: begin
        issue      = 1'b1;
        itag.op    = WB_QP;
        itag.idx   = g;
        itag.first = 1'b1;
        itag.last  = 1'b1;
        case (g)
          4'd0: begin opa = cur.quat_x; opb = cur.quat_x; end
          4'd1: begin opa = cur.quat_y; opb = cur.quat_y; end
          4'd2: begin opa = cur.quat_z; opb = cur.quat_z; end
          4'd3: begin opa = cur.quat_w; opb = cur.quat_w; end
          4'd4: begin opa = cur.quat_x; opb = cur.quat_y; end
          4'd5: begin opa = cur.quat_x; opb = cur.quat_z; end
          4'd6: begin opa = cur.quat_y; opb = cur.quat_z; end
          4'd7: begin opa = cur.quat_w; opb = cur.quat_x; end
          4'd8: begin opa = cur.quat_w; opb = cur.quat_y; end
          default: begin opa = cur.quat_w; opb = cur.quat_z; end
        endcase
      end
      PH_COMP: begin
        issue      = 1'b1;
        opa        = rr[ai];
        itag.first = (k == 2'd0);
        itag.last  = (k == 2'd2);
        if (g < 4'd9) begin
          opb      = wr[bi];
          itag.op  = WB_CR;
          itag.idx = g;
        end else begin
          opb      = posk;
          itag.op  = WB_CT;
          itag.idx = 4'(row);
        end
      end
      PH_CTR: begin
        issue      = 1'b1;
        opa        = cr[pi];
        opb        = WS_PT[k];
        itag.op    = WB_DD;
        itag.idx   = g;
        itag.first = (k == 2'd0);
        itag.last  = (k == 2'd2);
      end
      PH_SQ: begin
        issue = 1'b1;
        if (g < 4'd3) begin
          opa        = dd[g[1:0]];
          opb        = dd[g[1:0]];
          itag.op    = WB_SQ;
          itag.first = (g == 4'd0);
        end else begin
          opa       = {1'b0, hand_radius};
          opb       = {1'b0, hand_radius};
          itag.op   = WB_HR;
          itag.last = 1'b1;
        end
      end
      PH_ZCHK: begin
        issue      = 1'b1;
        itag.first = (k == 2'd0);
        itag.last  = (k == 2'd2);
        if (fm) begin
          opa     = cr[4'(k) * 4'd3 + 4'd2];
          opb     = sat32(66'(PALM[pi]) - 66'(ct[k]));
          itag.op = WB_ZM;
        end else begin
          opa     = cr[4'd6 + 4'(k)];
          opb     = PALM[pi];
          itag.op = WB_ZF;
        end
      end
      PH_IDLE, PH_ROT, PH_FIN: begin
        issue = 1'b0;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (tag.op == WB_SQ || tag.op == WB_HR) begin
      term = 66'(prod);
    end else begin
      term = 66'(prod >>> 30);
    end
    case (tag.op)
      WB_CT:   init = 66'(rt[tag.idx[1:0]]);
      WB_DD:   init = 66'(ct[tag.idx[1:0]]);
      WB_ZF:   init = 66'(ct[2]);
      default: init = '0;
    endcase
    sum         = (tag.first ? init : acc) + term;
    new_verdict = verdict && (why == WHY_NONE);
    new_code    = (verdict && why != WHY_NONE) ? why : code;
  end

  assign sweep_end = (g == 4'd2) && (k == 2'd2);

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    tag  <= itag;
    if (pv) begin
      if (tag.op != WB_HR) begin
        acc <= sum;
      end
      if (tag.last) begin
        case (tag.op)
          WB_QP:   qp[tag.idx] <= sum[33:0];
          WB_CR:   cr[tag.idx] <= sat32(sum);
          WB_CT:   ct[tag.idx[1:0]] <= sat32(sum);
          WB_DD:   dd[tag.idx[1:0]] <= sat32(sum - 66'(WS_PT[tag.idx[1:0]]));
          default: ;
        endcase
      end
    end
    if (q_pop) begin
      cur <= q_head;
    end
    if (phase == PH_ROT && !pv) begin
      if (cur.load) begin
        rr    <= rot_now;
        rt[0] <= cur.pos_x;
        rt[1] <= cur.pos_y;
        rt[2] <= cur.pos_z;
      end else begin
        wr <= rot_now;
      end
    end
    if (phase == PH_FIN && !pv && (!ov || m_tready)) begin
      out_ok  <= new_verdict;
      out_why <= new_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      g       <= '0;
      k       <= '0;
      pv      <= 1'b0;
      why     <= WHY_NONE;
      verdict <= 1'b1;
      code    <= WHY_NONE;
      fm      <= 1'b0;
      sm      <= 1'b0;
      ov      <= 1'b0;
    end else begin
      pv <= issue;
      if (ov && m_tready) begin
        ov <= 1'b0;
      end
      if (pv && tag.last) begin
        if (tag.op == WB_HR && acc < {prod[63:0], 2'b00}) begin
          why <= WHY_CLOSE;
        end else if ((tag.op == WB_ZM || tag.op == WB_ZF) && sum <= 66'sd0) begin
          why <= WHY_BELOW;
        end
      end
      unique case (phase)
        PH_IDLE: begin
          g <= '0;
          k <= '0;
          if (q_valid) begin
            why <= WHY_NONE;
            if (q_head.load) begin
              phase <= PH_QUAT;
            end else if (!verdict) begin
              phase <= PH_FIN;
            end else if (!fm && !sm) begin
              why   <= WHY_FIXED;
              phase <= PH_FIN;
            end else begin
              phase <= PH_QUAT;
            end
          end
        end
        PH_QUAT: begin
          g <= g + 4'd1;
          if (g == 4'd9) begin
            g     <= '0;
            phase <= PH_ROT;
          end
        end
        PH_ROT: begin
          if (!pv) begin
            if (cur.load) begin
              fm      <= cur.mob_first;
              sm      <= cur.mob_second;
              verdict <= 1'b1;
              code    <= WHY_NONE;
              phase   <= PH_FIN;
            end else begin
              phase <= PH_COMP;
            end
          end
        end
        PH_COMP: begin
          k <= k + 2'd1;
          if (k == 2'd2) begin
            k <= '0;
            g <= g + 4'd1;
            if (g == 4'd11) begin
              g     <= '0;
              phase <= (fm && sm) ? PH_CTR : PH_ZCHK;
            end
          end
        end
        PH_CTR: begin
          k <= k + 2'd1;
          if (k == 2'd2) begin
            k <= '0;
            g <= g + 4'd1;
            if (sweep_end) begin
              g     <= '0;
              phase <= PH_SQ;
            end
          end
        end
        PH_SQ: begin
          g <= g + 4'd1;
          if (g == 4'd3) begin
            g     <= '0;
            phase <= PH_FIN;
          end
        end
        PH_ZCHK: begin
          k <= k + 2'd1;
          if (k == 2'd2) begin
            k <= '0;
            g <= g + 4'd1;
            if (sweep_end) begin
              g     <= '0;
              phase <= PH_FIN;
            end
          end
        end
        PH_FIN: begin
          if (!pv) begin
            if (cur.last) begin
              if (!ov || m_tready) begin
                ov      <= 1'b1;
                verdict <= 1'b1;
                code    <= WHY_NONE;
                phase   <= PH_IDLE;
              end
            end else begin
              verdict <= new_verdict;
              code    <= new_code;
              phase   <= PH_IDLE;
            end
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/pose_transition_clearance_check.sv]
// Top level of the pose transition clearance check: stream ports, register port, front and back.
`timescale 1ns / 1ps
// A load request (tuser 0) sets the reference pose and the two mobility flags and opens a run;
// each waypoint request (tuser 1) is composed with the reference and checked by the mode the
// flags select, and the first failure of a run is kept. A request with tlast set yields one
// result: bit 0 is 1 when the run passed, bits 2:1 give the reason (1 hands too close, 2 palm
// point at or below the table, 3 both fixed). One signed 32x32 multiplier is shared by every
// product, one product per cycle; waypoints after a failure and waypoints with both effectors
// fixed issue no products. A result that waits in the output register holds the back end in
// its last step until it is taken.
// A two-entry request queue lets the next request be taken while one is worked on, and a
// finished result waits in the output register. hand_radius sits at byte address 0.
module pose_transition_clearance_check import ptcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, mobility_first, mobility_second
  input  logic [DATA_W-1:0] s_tdata,
  // opcode
  input  logic              s_tuser,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  // transition_valid, fail_reason
  output logic [7:0]        m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic        q_valid;
  logic        q_pop;
  req_t        q_head;
  logic [30:0] hand_radius;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {1'b0, hand_radius} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hand_radius <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      hand_radius <= pwdata[30:0];
    end
  end

  ptcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  ptcc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_head      (q_head),
    .hand_radius (hand_radius),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

[hdl/ptcc_checker.sv]
// Port-level assertions for the pose transition clearance check, bound to the top level.
`timescale 1ns / 1ps
module ptcc_checker import ptcc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [7:0]        m_tdata
);

  a_pass_no_reason : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[2:1] == 2'd0)
    else $error("passing result carries a failure reason");

  a_fail_has_reason : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[2:1] != 2'd0)
    else $error("failing result carries no reason");

  a_reset_clears_out : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_holds : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind pose_transition_clearance_check ptcc_checker u_ptcc_checker (.*);
